// ===== design/vn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the vector normalization pipeline.
// No dependencies; imported by every module of the block.
package vn_pkg;

  localparam int COMP_W     = 32;            // Q16.16 component width
  localparam int SUM_W      = 2 * COMP_W;    // Q32.32 sum of squares
  localparam int ROOT_W     = COMP_W;        // one root bit per stage
  localparam int QUO_W      = 17;            // quotient 0..65536
  localparam int UNIT_W     = QUO_W + 1;     // signed Q1.16
  localparam int FRAC_W     = 16;
  localparam int SQ_LAT     = 3;             // abs, square, sum
  localparam int ROOT_LAT   = ROOT_W;
  localparam int DIV_LAT    = QUO_W;
  localparam int PIPE_LAT   = SQ_LAT + ROOT_LAT + DIV_LAT + 1;

  // Sign and magnitude of one component.
  typedef struct packed {
    logic              neg;
    logic [COMP_W-1:0] mag;
  } comp_t;

endpackage

// ===== design/vector3_normalize.sv =====
`timescale 1ns / 1ps
// Top level of the 3D vector normalizer: square/sum, root and divide pipeline.
// Depends on vn_pkg, vn_square, vn_sqrt and vn_div.
//
//  channel | dir | payload
//  --------+-----+-----------------------------------------------------------
//  in_     | in  | tdata = vec_x, vec_y, vec_z (3 x 32, signed Q16.16)
//  out_    | out | tdata = unit_x, unit_y, unit_z (3 x 18), magnitude (32);
//          |     | tuser = zero_length
//
// One transaction enters per cycle unless the pipeline holds; its stages are
// abs/square/sum, the root (one bit per stage), the dividers (one quotient
// bit per stage) and one output register.
// The whole pipeline advances together; it holds while the output register
// is full and not taken, so a stall drops and repeats nothing.
// Reset clears only the valid bits.
module vector3_normalize import vn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // unit_x, unit_y, unit_z (18 each), magnitude
  output logic        out_tuser   // zero_length
);

  localparam int VLD_N = PIPE_LAT - 1;

  logic               en;
  logic [VLD_N-1:0]   vld_r;
  logic               out_vld_r;
  logic [SUM_W-1:0]   sum;
  comp_t              sq_comp [3];
  logic [ROOT_W-1:0]  root;
  comp_t              rt_comp [3];
  logic [QUO_W-1:0]   quo [3];
  logic               neg [3];
  logic [ROOT_W-1:0]  len [3];
  logic [UNIT_W-1:0]  unit_r [3];
  logic [ROOT_W-1:0]  mag_r;
  logic               zero_r;

  // Advance everything when the output register is free or being drained.
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[VLD_N-2:0], in_tvalid};
      out_vld_r <= vld_r[VLD_N-1];
    end
  end

  vn_square u_square (
    .clk   (clk),
    .en    (en),
    .vec_x (in_tdata[31:0]),
    .vec_y (in_tdata[63:32]),
    .vec_z (in_tdata[95:64]),
    .sum   (sum),
    .comp  (sq_comp)
  );

  vn_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad      (sum),
    .comp_in  (sq_comp),
    .root     (root),
    .comp_out (rt_comp)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    vn_div u_div (
      .clk     (clk),
      .en      (en),
      .mag     (rt_comp[i].mag),
      .neg     (rt_comp[i].neg),
      .len     (root),
      .quo     (quo[i]),
      .neg_out (neg[i]),
      .len_out (len[i])
    );
  end

  // Apply signs; drop the quotient when the length is zero.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (len[0] == '0) begin
          unit_r[i] <= '0;
        end else if (neg[i]) begin
          unit_r[i] <= UNIT_W'(0) - {1'b0, quo[i]};
        end else begin
          unit_r[i] <= {1'b0, quo[i]};
        end
      end
      mag_r  <= len[0];
      zero_r <= (len[0] == '0);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, mag_r, unit_r[2], unit_r[1], unit_r[0]};
  assign out_tuser  = zero_r;

endmodule

// ===== design/vn_square.sv =====
`timescale 1ns / 1ps
// Front end: absolute values, three squares and their exact 64-bit sum.
// Depends on vn_pkg.
module vn_square import vn_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [COMP_W-1:0] vec_x,
  input  logic signed [COMP_W-1:0] vec_y,
  input  logic signed [COMP_W-1:0] vec_z,
  output logic [SUM_W-1:0]         sum,
  output comp_t                    comp [3]
);

  comp_t             abs_r [3];
  comp_t             sq_c_r [3];
  comp_t             sum_c_r [3];
  logic [SUM_W-1:0]  sq_r [3];
  logic [SUM_W-1:0]  sum_r;
  logic [COMP_W-1:0] raw [3];

  assign raw[0] = vec_x;
  assign raw[1] = vec_y;
  assign raw[2] = vec_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        abs_r[i].neg  <= raw[i][COMP_W-1];
        abs_r[i].mag  <= raw[i][COMP_W-1] ? (~raw[i] + 1'b1) : raw[i];
        sq_r[i]       <= abs_r[i].mag * abs_r[i].mag;
        sq_c_r[i]     <= abs_r[i];
        sum_c_r[i]    <= sq_c_r[i];
      end
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  assign sum  = sum_r;
  assign comp = sum_c_r;

endmodule

// ===== design/vn_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined floor square root, one root bit per register stage.
// Depends on vn_pkg.
module vn_sqrt import vn_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  rad,
  input  comp_t             comp_in [3],
  output logic [ROOT_W-1:0] root,
  output comp_t             comp_out [3]
);

  localparam int REM_W = ROOT_W + 3;

  logic [SUM_W-1:0]  bits_r [ROOT_LAT];
  logic [REM_W-1:0]  rem_r  [ROOT_LAT];
  logic [ROOT_W-1:0] root_r [ROOT_LAT];
  comp_t             comp_r [ROOT_LAT][3];

  for (genvar s = 0; s < ROOT_LAT; s++) begin : g_stage
    logic [SUM_W-1:0]  bits_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    comp_t             comp_prev [3];
    logic [REM_W-1:0]  r2;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign bits_in   = rad;
      assign rem_in    = '0;
      assign root_in   = '0;
      assign comp_prev = comp_in;
    end else begin : g_next
      assign bits_in   = bits_r[s-1];
      assign rem_in    = rem_r[s-1];
      assign root_in   = root_r[s-1];
      assign comp_prev = comp_r[s-1];
    end

    // Bring down the next two radicand bits; try (root << 2) | 1.
    assign r2    = {rem_in[REM_W-3:0], bits_in[SUM_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        bits_r[s] <= {bits_in[SUM_W-3:0], 2'b00};
        rem_r[s]  <= ge ? (r2 - trial) : r2;
        root_r[s] <= {root_in[ROOT_W-2:0], ge};
        comp_r[s] <= comp_prev;
      end
    end
  end

  assign root     = root_r[ROOT_LAT-1];
  assign comp_out = comp_r[ROOT_LAT-1];

endmodule

// ===== design/vn_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: (mag << 16) / len, one quotient bit per stage.
// Depends on vn_pkg.
module vn_div import vn_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [COMP_W-1:0] mag,
  input  logic              neg,
  input  logic [ROOT_W-1:0] len,
  output logic [QUO_W-1:0]  quo,
  output logic              neg_out,
  output logic [ROOT_W-1:0] len_out
);

  logic [ROOT_W-1:0] rem_r [DIV_LAT];
  logic [QUO_W-1:0]  quo_r [DIV_LAT];
  logic [ROOT_W-1:0] len_r [DIV_LAT];
  logic              neg_r [DIV_LAT];
  logic              lsb_r;

  // Since mag <= len the quotient fits QUO_W bits, so start at mag >> 1.
  for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
    logic [ROOT_W-1:0] rem_in;
    logic [QUO_W-1:0]  quo_in;
    logic [ROOT_W-1:0] len_in;
    logic              neg_in;
    logic              nb;
    logic [ROOT_W:0]   r2;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = {1'b0, mag[COMP_W-1:1]};
      assign quo_in = '0;
      assign len_in = len;
      assign neg_in = neg;
      assign nb     = mag[0];
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign len_in = len_r[s-1];
      assign neg_in = neg_r[s-1];
      assign nb     = (s == 1) ? lsb_r : 1'b0;
    end

    assign r2 = {rem_in, nb};
    assign ge = (r2 >= {1'b0, len_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? ROOT_W'(r2 - {1'b0, len_in}) : r2[ROOT_W-1:0];
        quo_r[s] <= {quo_in[QUO_W-2:0], ge};
        len_r[s] <= len_in;
        neg_r[s] <= neg_in;
      end
    end
  end

  // The input lsb is consumed in stage 0 only; lsb_r holds zero and feeds stage 1.
  always_ff @(posedge clk) begin
    if (en) begin
      lsb_r <= 1'b0;
    end
  end

  assign quo     = quo_r[DIV_LAT-1];
  assign neg_out = neg_r[DIV_LAT-1];
  assign len_out = len_r[DIV_LAT-1];

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for vector3_normalize: drives Q16.16 vectors on the input stream
// and checks length, unit vector and zero flag. Depends on vn_pkg and the RTL.
module tb;
  import vn_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [UNIT_W-1:0] ux;
    logic [UNIT_W-1:0] uy;
    logic [UNIT_W-1:0] uz;
    logic [31:0]       len;
    logic              zero_len;
  } norm_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tuser;

  norm_t expected_norms[$];
  int    fail_count = 0;
  int    idle_pct = 32;   // idling odds on both sides, in percent
  int    stall_cycles = 0;

  vector3_normalize uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Floor square root, digit by digit.
  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [63:0] rem, root, bitv;
    rem = v;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root[31:0];
  endfunction

  function automatic logic [UNIT_W-1:0] unit_of(logic [31:0] c, logic [31:0] len);
    logic [63:0] mag, q;
    mag = c[31] ? {32'd0, -c} : {32'd0, c};
    q = (mag << FRAC_W) / {32'd0, len};
    if (c[31]) q = -q;
    return q[UNIT_W-1:0];
  endfunction

  function automatic norm_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    norm_t r;
    logic [63:0] ax, ay, az, sum;
    ax = x[31] ? {32'd0, -x} : {32'd0, x};
    ay = y[31] ? {32'd0, -y} : {32'd0, y};
    az = z[31] ? {32'd0, -z} : {32'd0, z};
    sum = ax * ax + ay * ay + az * az;
    r = '0;
    r.len = floor_sqrt(sum);
    if (r.len == 0) begin
      r.zero_len = 1'b1;
    end else begin
      r.ux = unit_of(x, r.len);
      r.uy = unit_of(y, r.len);
      r.uz = unit_of(z, r.len);
    end
    return r;
  endfunction

  // Send one vector after random gaps with tvalid low; advance on handshake.
  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_norms.push_back(normalize(x, y, z));
  endtask

  task automatic drop_valid();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Random out_tready; watchdog on cycles without any transaction.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (rst_n) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    norm_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ux       = out_tdata[17:0];
      got.uy       = out_tdata[35:18];
      got.uz       = out_tdata[53:36];
      got.len      = out_tdata[85:54];
      got.zero_len = out_tuser;
      if (expected_norms.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = expected_norms.pop_front();
        if (got.ux !== want.ux)
          $display("%0t: unit_x exp %h got %h", $time, want.ux, got.ux);
        if (got.uy !== want.uy)
          $display("%0t: unit_y exp %h got %h", $time, want.uy, got.uy);
        if (got.uz !== want.uz)
          $display("%0t: unit_z exp %h got %h", $time, want.uz, got.uz);
        if (got.len !== want.len)
          $display("%0t: magnitude exp %h got %h", $time, want.len, got.len);
        if (got.zero_len !== want.zero_len)
          $display("%0t: zero_length exp %b got %b", $time, want.zero_len, got.zero_len);
        if (got !== want) fail_count++;
      end
    end
  end

  // Extremes, zero vector, axis vectors and the most negative component.
  task automatic test_directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send_vector(0, 0, 0);
    send_vector(1, 0, 0);
    send_vector(0, 32'hffff_ffff, 0);
    send_vector(0, 0, 32'h0001_0000);
    send_vector(mn, 0, 0);
    send_vector(mn, mn, mn);
    send_vector(mx, mx, mx);
    send_vector(mx, mn, mx);
    send_vector(0, mx, 0);
    send_vector(1, 1, 1);
    send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vector(32'h0003_0000, 32'h0004_0000, 0);
    send_vector(32'hfffd_0000, 0, 32'h0004_0000);
    send_vector(mn, 1, 32'hffff_ffff);
    send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    drop_valid();
  endtask

  // Random vectors of mixed scale so short and long lengths both occur.
  task automatic test_random(int n);
    logic [31:0] c[3];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        c[k] = $urandom();
        case ($urandom_range(3))
          0: c[k] = $signed(c[k]) >>> $urandom_range(31);
          1: c[k] = $signed(c[k]) >>> 24;
          default: ;
        endcase
        if ($urandom_range(15) == 0) c[k] = '0;
      end
      send_vector(c[0], c[1], c[2]);
    end
    drop_valid();
  endtask

  // Back-to-back stretch with no idling on either side.
  task automatic test_streaming(int n);
    idle_pct = 0;
    test_random(n);
    idle_pct = 32;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1300);
    test_streaming(400);
    test_random(200);
    // Drain, then allow the pipeline latency to flush stray results.
    while (expected_norms.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/vn_pkg.sv
design/vn_square.sv
design/vn_sqrt.sv
design/vn_div.sv
design/vector3_normalize.sv
verif/tb.sv
